FILE: rtl/mvpm_pkg.sv
// Package for the multi-voice PCM mixer: default parameters, command codes and sequencer states.
package mvpm_pkg;

	localparam int VOICES_DEFAULT        = 8;
	localparam int SAMPLE_DEPTH_DEFAULT  = 16384;
	localparam int FRACTION_BITS_DEFAULT = 16;

	localparam logic [15:0] DEFAULT_RATE = 16'd11025;
	localparam int          STEP_W       = 32;
	localparam int          POS_W        = 33;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_MIX   = 2'd2,
		CMD_STOP  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_START_WR,
		ST_MIX_SCAN,
		ST_MIX_IDX,
		ST_MIX_ACC,
		ST_DONE
	} state_t;

	// Handshake between the sequencer and the step divider.
	typedef struct packed {
		logic        start;
		logic [15:0] rate;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [STEP_W-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: rtl/mvpm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mvpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/mvpm_stepdiv.sv
// Restoring divider, one quotient bit per cycle: step = (rate << FRACTION_BITS) / divisor.
module mvpm_stepdiv #(
	parameter int FRACTION_BITS = mvpm_pkg::FRACTION_BITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mvpm_pkg::div_req_t req,
	output mvpm_pkg::div_rsp_t rsp
);
	import mvpm_pkg::*;

	localparam int QW = 16 + FRACTION_BITS;
	localparam int CW = $clog2(QW + 1);

	logic [QW-1:0] dividend_q;
	logic [QW-1:0] quot_q;
	logic [16:0]   rem_q;
	logic [15:0]   divisor_q;
	logic [CW-1:0] count_q;
	logic          busy_q;
	logic          done_q;
	logic [16:0]   trial;
	logic          fits;

	always_comb begin
		trial = {rem_q[15:0], dividend_q[QW-1]};
		fits  = trial >= {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				count_q <= CW'(QW);
			end else if (busy_q) begin
				count_q <= count_q - 1'b1;
				if (count_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dividend_q <= {req.rate, {FRACTION_BITS{1'b0}}};
			divisor_q  <= req.divisor;
			rem_q      <= '0;
			quot_q     <= '0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[QW-2:0], 1'b0};
			rem_q      <= fits ? (trial - {1'b0, divisor_q}) : trial;
			quot_q     <= {quot_q[QW-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = STEP_W'(quot_q);
endmodule

FILE: rtl/multi_voice_pcm_mixer.sv
// Top level of the multi-voice PCM mixer: command sequencer, voice state and sample stores.
//
// Items enter on the input channel (in_valid / in_stall) and each gives exactly one
// result item on the output channel (out_valid / out_stall). The block works on one
// item at a time; a new item is taken while the previous result still waits.
// A load converts one PCM frame to an unsigned byte and writes it into the voice's
// sample store. A start runs the bit-serial step divider before it writes the voice.
// A start with a frame count of zero is rejected and goes straight to its result.
// A mix walks every voice: an idle voice is only scanned, a voice that ends is read
// from the voice state memory and cleared, and a playing voice needs a read of the
// voice state memory, then a read of the sample memory, then a write back of the
// advanced position. A stop clears all active bits and goes straight to its result.
// Reset clears all active bits and sets engine_rate to 11025; the sample store is not
// cleared and holds whatever was last loaded. Writing 0 to engine_rate gives 11025.
// When the receiver stalls, the result stays in the output register, the block
// finishes the next item and holds it until the output register frees up.
module multi_voice_pcm_mixer #(
	parameter int VOICES        = mvpm_pkg::VOICES_DEFAULT,
	parameter int SAMPLE_DEPTH  = mvpm_pkg::SAMPLE_DEPTH_DEFAULT,
	parameter int FRACTION_BITS = mvpm_pkg::FRACTION_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [2:0]  voice,
	input  logic [13:0] address,
	input  logic [15:0] first_raw,
	input  logic [15:0] second_raw,
	input  logic [14:0] frame_count,
	input  logic [15:0] source_rate,
	input  logic        wide_samples,
	input  logic        two_channels,
	input  logic [7:0]  mix_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  mixed_sample,
	output logic [2:0]  chosen_voice,
	output logic [7:0]  converted_byte,
	output logic [7:0]  active_mask
);
	import mvpm_pkg::*;

	localparam int VIW   = VOICES > 1 ? $clog2(VOICES) : 1;
	localparam int VCW   = $clog2(VOICES + 1);
	localparam int AW    = SAMPLE_DEPTH > 1 ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int LW    = $clog2(SAMPLE_DEPTH + 1);
	localparam int SDEP  = VOICES * SAMPLE_DEPTH;
	localparam int SW    = SDEP > 1 ? $clog2(SDEP) : 1;
	localparam int IW    = POS_W - FRACTION_BITS;
	localparam int CMPW  = (IW > LW ? IW : LW) + 1;
	localparam int VWORD = LW + STEP_W + POS_W;

	state_t state_q, state_next;

	logic [15:0]     engine_rate_q;
	logic [VOICES-1:0] active_q;
	logic            out_valid_q;
	logic [7:0]      mixed_q, conv_q, mask_q, out_conv_q;
	logic [2:0]      chosen_q, out_chosen_q;
	logic [1:0]      cmd_q;

	// Accepted item fields.
	logic [2:0]  voice_q;
	logic [13:0] address_q;
	logic [15:0] first_q, second_q;
	logic [14:0] frames_q;
	logic        wide_q, stereo_q;

	logic [7:0]     acc_q;
	logic [VCW-1:0] vcnt_q;
	logic [VIW-1:0] vidx;
	logic [LW-1:0]  len_q;
	logic [STEP_W-1:0] step_q;
	logic [POS_W-1:0]  pos_q;

	logic accept, out_free;
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign vidx     = vcnt_q[VIW-1:0];

	// Divider.
	div_req_t div_req;
	div_rsp_t div_rsp;

	mvpm_stepdiv #(.FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	always_comb begin
		div_req.start   = accept && (cmd_t'(cmd) == CMD_START) && (frame_count != 15'd0);
		div_req.rate    = (source_rate == 16'd0) ? engine_rate_q : source_rate;
		div_req.divisor = engine_rate_q;
	end

	// Frame conversion.
	logic [7:0] ch_a, ch_b, conv_byte;
	logic [8:0] ch_sum;
	always_comb begin
		ch_a      = wide_q ? {~first_q[15], first_q[14:8]} : first_q[7:0];
		ch_b      = wide_q ? {~second_q[15], second_q[14:8]} : second_q[7:0];
		ch_sum    = {1'b0, ch_a} + {1'b0, ch_b};
		conv_byte = stereo_q ? ch_sum[8:1] : ch_a;
	end

	// Start: first free slot, or voice 0.
	logic [VIW-1:0] slot;
	always_comb begin
		slot = '0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				slot = VIW'(i);
			end
		end
	end

	logic [LW-1:0]     start_len;
	logic [STEP_W-1:0] start_step;
	always_comb begin
		start_len  = ({2'b00, frames_q} > 17'(SAMPLE_DEPTH)) ?
			LW'(SAMPLE_DEPTH) : LW'(frames_q);
		start_step = (div_rsp.quotient == '0) ? STEP_W'(1) : div_rsp.quotient;
	end

	// Voice state memory.
	logic             vram_we;
	logic [VIW-1:0]   vram_waddr;
	logic [VWORD-1:0] vram_wdata, vram_rdata;

	mvpm_ram #(.WIDTH(VWORD), .DEPTH(VOICES)) u_vram (
		.clk(clk), .we(vram_we), .waddr(vram_waddr), .wdata(vram_wdata),
		.raddr(vidx), .rdata(vram_rdata)
	);

	// Sample memory.
	logic          sram_we;
	logic [SW-1:0] sram_waddr, sram_raddr;
	logic [7:0]    sram_rdata;
	logic          load_in_range;

	mvpm_ram #(.WIDTH(8), .DEPTH(SDEP)) u_sram (
		.clk(clk), .we(sram_we), .waddr(sram_waddr), .wdata(conv_byte),
		.raddr(sram_raddr), .rdata(sram_rdata)
	);

	// Mix arithmetic.
	logic [LW-1:0]     rd_len;
	logic [STEP_W-1:0] rd_step;
	logic [POS_W-1:0]  rd_pos;
	logic [IW-1:0]     rd_idx;
	logic              voice_ends;
	logic [9:0]        sum;
	logic [7:0]        sum_sat;

	always_comb begin
		{rd_len, rd_step, rd_pos} = vram_rdata;
		rd_idx     = rd_pos[POS_W-1:FRACTION_BITS];
		voice_ends = CMPW'(rd_idx) >= CMPW'(rd_len);
		load_in_range = ({2'b00, voice_q} < 5'(VOICES)) &&
			({3'b0, address_q} < 17'(SAMPLE_DEPTH));
		sram_waddr = SW'(voice_q) * SW'(SAMPLE_DEPTH) + SW'(address_q);
		sram_raddr = SW'(vidx) * SW'(SAMPLE_DEPTH) + SW'(rd_idx[AW-1:0]);
		sum        = {2'b00, acc_q} + {2'b00, sram_rdata} - 10'd128;
		sum_sat    = sum[9] ? 8'd0 : (sum[8] ? 8'd255 : sum[7:0]);
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd_t'(cmd))
						CMD_LOAD:  state_next = ST_LOAD;
						CMD_START: state_next = (frame_count != 15'd0) ? ST_DIV : ST_DONE;
						CMD_MIX:   state_next = ST_MIX_SCAN;
						default:   state_next = ST_DONE;
					endcase
				end
			end
			ST_LOAD:     state_next = ST_DONE;
			ST_DIV:      state_next = div_rsp.done ? ST_START_WR : ST_DIV;
			ST_START_WR: state_next = ST_DONE;
			ST_MIX_SCAN: begin
				if (vcnt_q == VCW'(VOICES)) begin
					state_next = ST_DONE;
				end else if (active_q[vidx]) begin
					state_next = ST_MIX_IDX;
				end
			end
			ST_MIX_IDX:  state_next = voice_ends ? ST_MIX_SCAN : ST_MIX_ACC;
			ST_MIX_ACC:  state_next = ST_MIX_SCAN;
			ST_DONE:     state_next = out_free ? ST_IDLE : ST_DONE;
			default:     state_next = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall   = state_q != ST_IDLE;
		sram_we    = (state_q == ST_LOAD) && load_in_range;
		vram_we    = 1'b0;
		vram_waddr = vidx;
		vram_wdata = {len_q, step_q, pos_q + POS_W'(step_q)};
		case (state_q)
			ST_START_WR: begin
				vram_we    = 1'b1;
				vram_waddr = slot;
				vram_wdata = {start_len, start_step, {POS_W{1'b0}}};
			end
			ST_MIX_ACC: vram_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			engine_rate_q <= DEFAULT_RATE;
			active_q      <= '0;
			out_valid_q   <= 1'b0;
			vcnt_q        <= '0;
		end else begin
			state_q <= state_next;
			if (cfg_we) begin
				engine_rate_q <= (cfg_wdata == 16'd0) ? DEFAULT_RATE : cfg_wdata;
			end
			// A finished item refills the output register in the cycle it is taken.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					vcnt_q <= '0;
					if (accept && cmd_t'(cmd) == CMD_STOP) begin
						active_q <= '0;
					end
				end
				ST_START_WR: active_q[slot] <= 1'b1;
				ST_MIX_SCAN: begin
					if (vcnt_q != VCW'(VOICES) && !active_q[vidx]) begin
						vcnt_q <= vcnt_q + 1'b1;
					end
				end
				ST_MIX_IDX: begin
					if (voice_ends) begin
						active_q[vidx] <= 1'b0;
						vcnt_q         <= vcnt_q + 1'b1;
					end
				end
				ST_MIX_ACC: vcnt_q <= vcnt_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			voice_q   <= voice;
			address_q <= address;
			first_q   <= first_raw;
			second_q  <= second_raw;
			frames_q  <= frame_count;
			wide_q    <= wide_samples;
			stereo_q  <= two_channels;
			acc_q     <= mix_in;
			conv_q    <= 8'd0;
			chosen_q  <= 3'd0;
		end
		if (state_q == ST_LOAD) begin
			conv_q <= conv_byte;
		end
		if (state_q == ST_START_WR) begin
			chosen_q <= 3'(slot);
		end
		if (state_q == ST_MIX_IDX) begin
			len_q  <= rd_len;
			step_q <= rd_step;
			pos_q  <= rd_pos;
		end
		if (state_q == ST_MIX_ACC) begin
			acc_q <= sum_sat;
		end
		// The output register only changes when a finished item moves into it.
		if (state_q == ST_DONE && out_free) begin
			mixed_q      <= (cmd_t'(cmd_q) == CMD_MIX) ? acc_q : 8'd0;
			out_conv_q   <= conv_q;
			out_chosen_q <= chosen_q;
			for (int i = 0; i < 8; i++) begin
				mask_q[i] <= (i < VOICES) ? active_q[i % VOICES] : 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign mixed_sample   = mixed_q;
	assign chosen_voice   = out_chosen_q;
	assign converted_byte = out_conv_q;
	assign active_mask    = mask_q;
endmodule

FILE: tb/tb_multi_voice_pcm_mixer.sv
// Self-checking testbench for the multi-voice PCM mixer: directed table, random sequences, checks.
module tb_multi_voice_pcm_mixer;
	import mvpm_pkg::*;

	localparam int NV = 8;
	localparam int DEPTH = 16384;
	localparam int FB = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_LEN = 500;

	// One input item as the block sees it on its ports.
	typedef struct {
		cmd_t        op;
		logic [2:0]  vc;
		logic [13:0] addr;
		logic [15:0] raw_a;
		logic [15:0] raw_b;
		logic [14:0] frames;
		logic [15:0] srate;
		logic        wide;
		logic        stereo;
		logic [7:0]  base;
	} mixer_cmd_t;

	// One result item, compared field by field.
	typedef struct packed {
		logic [7:0] mixed;
		logic [2:0] chosen;
		logic [7:0] conv;
		logic [7:0] mask;
	} mixer_out_t;

	typedef struct {
		mixer_cmd_t c;
		bit         known;
		mixer_out_t r;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = '0;
	logic [2:0]  voice = '0;
	logic [13:0] address = '0;
	logic [15:0] first_raw = '0;
	logic [15:0] second_raw = '0;
	logic [14:0] frame_count = '0;
	logic [15:0] source_rate = '0;
	logic        wide_samples = 1'b0;
	logic        two_channels = 1'b0;
	logic [7:0]  mix_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  mixed_sample;
	logic [2:0]  chosen_voice;
	logic [7:0]  converted_byte;
	logic [7:0]  active_mask;

	multi_voice_pcm_mixer dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .voice(voice),
		.address(address), .first_raw(first_raw), .second_raw(second_raw),
		.frame_count(frame_count), .source_rate(source_rate),
		.wide_samples(wide_samples), .two_channels(two_channels), .mix_in(mix_in),
		.out_valid(out_valid), .out_stall(out_stall), .mixed_sample(mixed_sample),
		.chosen_voice(chosen_voice), .converted_byte(converted_byte),
		.active_mask(active_mask)
	);

	always #5 clk = ~clk;

	// Shadow of the block's state, advanced in the order items are offered.
	logic [7:0]  shadow_store [0:NV*DEPTH-1];
	bit          loaded [0:NV*DEPTH-1];
	logic        sh_active [NV];
	logic [14:0] sh_length [NV];
	logic [32:0] sh_pos [NV];
	logic [31:0] sh_step [NV];
	logic [15:0] sh_engine;

	mixer_out_t pending_results [$];
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int starts_sent = 0;
	int mixes_sent = 0;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_go = 1'b0;
	int hold_cycles = 0;
	dir_row_t dir_rows [$];

	function automatic logic [7:0] channel_byte(logic [15:0] raw, logic wide);
		return wide ? {~raw[15], raw[14:8]} : raw[7:0];
	endfunction

	function automatic int free_slot();
		for (int i = 0; i < NV; i++)
			if (!sh_active[i])
				return i;
		return 0;
	endfunction

	// A mix must never read a store entry that was not loaded; such a mix is replaced.
	function automatic bit mix_reads_unloaded();
		logic [32:0] idx;
		for (int i = 0; i < NV; i++) begin
			idx = sh_pos[i] >> FB;
			if (sh_active[i] && idx < sh_length[i] && !loaded[i*DEPTH + idx])
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic mixer_out_t predict_mixer(mixer_cmd_t c);
		mixer_out_t r;
		logic [8:0]  conv_sum;
		logic [15:0] rate;
		logic [47:0] scaled;
		logic [31:0] st;
		logic [32:0] idx;
		int          slot;
		int          acc;
		r = '{default: '0};
		case (c.op)
			CMD_LOAD: begin
				conv_sum = channel_byte(c.raw_a, c.wide);
				if (c.stereo)
					conv_sum = (conv_sum + channel_byte(c.raw_b, c.wide)) >> 1;
				r.conv = conv_sum[7:0];
				shadow_store[c.vc*DEPTH + c.addr] = conv_sum[7:0];
				loaded[c.vc*DEPTH + c.addr] = 1'b1;
			end
			CMD_START: begin
				if (c.frames != 0) begin
					slot = free_slot();
					rate = (c.srate == 0) ? sh_engine : c.srate;
					scaled = {16'd0, rate, 16'd0} / sh_engine;
					st = scaled[31:0];
					if (st == 0)
						st = 1;
					sh_length[slot] = (c.frames > DEPTH) ? 15'(DEPTH) : c.frames;
					sh_pos[slot] = '0;
					sh_step[slot] = st;
					sh_active[slot] = 1'b1;
					r.chosen = slot[2:0];
				end
			end
			CMD_MIX: begin
				acc = c.base;
				for (int i = 0; i < NV; i++) begin
					if (sh_active[i]) begin
						idx = sh_pos[i] >> FB;
						if (idx >= sh_length[i]) begin
							sh_active[i] = 1'b0;
						end else begin
							acc = acc + int'(shadow_store[i*DEPTH + idx]) - 128;
							if (acc < 0)
								acc = 0;
							if (acc > 255)
								acc = 255;
							sh_pos[i] = sh_pos[i] + 33'(sh_step[i]);
						end
					end
				end
				r.mixed = acc[7:0];
			end
			default: begin
				for (int i = 0; i < NV; i++)
					sh_active[i] = 1'b0;
			end
		endcase
		for (int i = 0; i < NV; i++)
			r.mask[i] = sh_active[i];
		return r;
	endfunction

	function automatic mixer_cmd_t make_cmd(cmd_t op, int vc, int addr, int ra, int rb,
			int frames, int srate, bit wide, bit stereo, int base);
		mixer_cmd_t c;
		c.op = op;
		c.vc = vc[2:0];
		c.addr = addr[13:0];
		c.raw_a = ra[15:0];
		c.raw_b = rb[15:0];
		c.frames = frames[14:0];
		c.srate = srate[15:0];
		c.wide = wide;
		c.stereo = stereo;
		c.base = base[7:0];
		return c;
	endfunction

	function automatic mixer_cmd_t random_cmd();
		return make_cmd(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 7),
			$urandom_range(0, DEPTH-1), $urandom, $urandom, $urandom_range(0, 32767),
			$urandom, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 255));
	endfunction

	function automatic void add_row(mixer_cmd_t c, bit known, int m, int ch, int cv, int mk);
		dir_row_t row;
		row.c = c;
		row.known = known;
		row.r = '{mixed: m[7:0], chosen: ch[2:0], conv: cv[7:0], mask: mk[7:0]};
		dir_rows.push_back(row);
	endfunction

	// Offers one item and returns once the block has taken it. Inputs change only at
	// the falling edge; the handshake is judged at the rising edge.
	task automatic offer_item(mixer_cmd_t c, bit known, mixer_out_t known_r);
		mixer_out_t pred;
		if (c.op == CMD_MIX && mix_reads_unloaded())
			c.op = CMD_STOP;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		pred = predict_mixer(c);
		pending_results.push_back(known ? known_r : pred);
		in_valid <= 1'b1;
		cmd <= c.op;
		voice <= c.vc;
		address <= c.addr;
		first_raw <= c.raw_a;
		second_raw <= c.raw_b;
		frame_count <= c.frames;
		source_rate <= c.srate;
		wide_samples <= c.wide;
		two_channels <= c.stereo;
		mix_in <= c.base;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		items_sent++;
		if (c.op == CMD_START)
			starts_sent++;
		if (c.op == CMD_MIX)
			mixes_sent++;
	endtask

	task automatic send(mixer_cmd_t c);
		offer_item(c, 1'b0, '{default: '0});
	endtask

	// Register writes happen only with nothing in flight.
	task automatic write_engine_rate(logic [15:0] value);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sh_engine = (value == 0) ? DEFAULT_RATE : value;
	endtask

	// Most of the random traffic loads a short sound into the slot that the next start
	// will take, starts it and mixes it out; the rest is unstructured noise.
	task automatic random_phase(int count);
		int goal;
		int slot;
		int len;
		bit wide;
		bit stereo;
		int frames;
		goal = items_sent + count;
		while (items_sent < goal) begin
			if ($urandom_range(0, 9) < 7) begin
				slot = free_slot();
				len = $urandom_range(1, 24);
				wide = $urandom_range(0, 1);
				stereo = $urandom_range(0, 1);
				for (int a = 0; a < len; a++)
					send(make_cmd(CMD_LOAD, slot, a, $urandom, $urandom, 0, 0, wide, stereo, 0));
				case ($urandom_range(0, 9))
					0: frames = 0;
					1: frames = $urandom_range(DEPTH, 32767);
					default: frames = $urandom_range(1, len);
				endcase
				send(make_cmd(CMD_START, $urandom_range(0, 7), $urandom, 0, 0, frames,
					($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535), wide, stereo, 0));
				repeat ($urandom_range(1, 30))
					send(make_cmd(CMD_MIX, $urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom_range(0, 255)));
				if ($urandom_range(0, 5) == 0)
					send(make_cmd(CMD_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
			end else begin
				send(random_cmd());
			end
		end
	endtask

	// The receiver stalls at random, or holds off entirely while a long hold is counting.
	always @(negedge clk) begin
		if (hold_go && hold_cycles < HOLD_LEN) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles + 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Every accepted result is matched against the oldest expectation.
	always @(posedge clk) begin
		mixer_out_t got;
		mixer_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{mixed: mixed_sample, chosen: chosen_voice,
				conv: converted_byte, mask: active_mask};
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: mixed %h chosen %0d conv %h mask %b",
						got.mixed, got.chosen, got.conv, got.mask);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result %0d: expected mixed %h chosen %0d conv %h mask %b,",
							" got mixed %h chosen %0d conv %h mask %b"},
							results_seen, want.mixed, want.chosen, want.conv, want.mask,
							got.mixed, got.chosen, got.conv, got.mask);
				end
			end
		end
	end

	// The watchdog ends a run that hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int wait_cycles;
		for (int i = 0; i < NV; i++) begin
			sh_active[i] = 1'b0;
			sh_length[i] = '0;
			sh_pos[i] = '0;
			sh_step[i] = '0;
		end
		for (int i = 0; i < NV*DEPTH; i++)
			loaded[i] = 1'b0;
		sh_engine = DEFAULT_RATE;

		// Directed rows: after reset, conversion extremes, rejected start, saturated
		// length, tiny and huge steps, every slot taken and the all-busy fallback.
		add_row(make_cmd(CMD_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 'hA5), 1, 'hA5, 0, 0, 0);
		add_row(make_cmd(CMD_LOAD, 0, 0, 'h00FF, 0, 0, 0, 0, 0, 0), 1, 0, 0, 'hFF, 0);
		add_row(make_cmd(CMD_LOAD, 0, 1, 'h8000, 0, 0, 0, 1, 0, 0), 1, 0, 0, 'h00, 0);
		add_row(make_cmd(CMD_LOAD, 0, 2, 'h7FFF, 0, 0, 0, 1, 0, 0), 1, 0, 0, 'hFF, 0);
		add_row(make_cmd(CMD_LOAD, 0, 3, 'h00FF, 'h0000, 0, 0, 0, 1, 0), 1, 0, 0, 'h7F, 0);
		add_row(make_cmd(CMD_LOAD, 0, 4, 'hFFFF, 'h0000, 0, 0, 1, 1, 0), 1, 0, 0, 'h7F, 0);
		add_row(make_cmd(CMD_LOAD, 0, 5, 'h7FFF, 'h7FFF, 0, 0, 1, 1, 0), 1, 0, 0, 'hFF, 0);
		add_row(make_cmd(CMD_START, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);
		add_row(make_cmd(CMD_START, 0, 0, 0, 0, 6, 0, 0, 0, 0), 1, 0, 0, 0, 1);
		add_row(make_cmd(CMD_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 'h80), 0, 0, 0, 0, 0);
		add_row(make_cmd(CMD_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 'hFF), 0, 0, 0, 0, 0);
		add_row(make_cmd(CMD_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 'h00), 0, 0, 0, 0, 0);
		for (int v = 1; v < NV; v++)
			add_row(make_cmd(CMD_LOAD, v, 0, v * 37, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
		add_row(make_cmd(CMD_START, 0, 0, 0, 0, 32767, 65535, 0, 0, 0), 0, 0, 0, 0, 0);
		add_row(make_cmd(CMD_START, 0, 0, 0, 0, 1, 1, 1, 1, 0), 0, 0, 0, 0, 0);
		add_row(make_cmd(CMD_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 'h40), 0, 0, 0, 0, 0);
		add_row(make_cmd(CMD_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);
		for (int v = 0; v <= NV; v++)
			add_row(make_cmd(CMD_START, 7, 0, 0, 0, 1, 0, 0, 0, 0), 0, 0, 0, 0, 0);
		add_row(make_cmd(CMD_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 'h7F), 0, 0, 0, 0, 0);
		add_row(make_cmd(CMD_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 'h7F), 0, 0, 0, 0, 0);

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			offer_item(dir_rows[i].c, dir_rows[i].known, dir_rows[i].r);

		// Each phase runs at its own engine rate, including both extremes and the
		// zero write that falls back to the default.
		write_engine_rate(16'd1);
		idle_pct = 0;
		stall_pct = 0;
		random_phase(210);
		write_engine_rate(16'd65535);
		idle_pct = 70;
		random_phase(210);
		write_engine_rate(16'd0);
		idle_pct = 0;
		stall_pct = 70;
		random_phase(210);
		write_engine_rate(16'($urandom_range(1, 65535)));
		idle_pct = 11;
		stall_pct = 11;
		random_phase(210);

		// The receiver holds off for a long stretch while items keep coming.
		write_engine_rate(16'd8000);
		idle_pct = 0;
		stall_pct = 0;
		hold_go = 1'b1;
		random_phase(210);

		in_valid <= 1'b0;
		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (60) @(posedge clk);
		$display("covered %0d items (%0d starts, %0d mixes) and %0d results in %0d cycles",
			items_sent, starts_sent, mixes_sent, results_seen, cycles);
		$display("five engine rates, sender and receiver idling, and one long receiver hold");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches,
				pending_results.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
